@@ hdl/assert_macros.svh @@
// Assertion macros shared by the vario tone generator RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check prop at every rising clock edge outside reset.
`define VTBG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check prop at every rising clock edge, reset included.
`define VTBG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VTBG_ASSERT(lbl, clk, rst, prop, msg)
`define VTBG_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hdl/vtbg_pkg.sv @@
// Package for the vario tone generator: widths, tables, register indexes
// and the request/response types of the serial interpolation unit.
// No dependencies.
`default_nettype none

package vtbg_pkg;

  localparam int RATE_W  = 13;
  localparam int FREQ_W  = 13;
  localparam int NUM_W   = 13;
  localparam int SPAN_W  = 15;
  localparam int DEN_W   = 12;
  localparam int BASE_W  = 14;
  localparam int PROD_W  = NUM_W + SPAN_W;
  localparam int LERP_W  = PROD_W + 2;
  localparam int MUL_STEPS = NUM_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W   = $clog2(PROD_W);

  localparam logic signed [RATE_W-1:0] MAX_CPS = 13'sd1000;
  localparam int SINK_SPAN_HZ   = 600;
  localparam int SINK_STEP_HZ   = 20;
  localparam int OFFSCALE_TICKS = 8;
  localparam int SINK_PERIOD    = 40;
  localparam int SINK_ON        = 30;
  localparam int ZEROES_PERIOD  = 30;
  localparam int ZEROES_ON      = 2;

  localparam logic [2:0] REG_SINK_TH   = 3'd0;
  localparam logic [2:0] REG_CLIMB_TH  = 3'd1;
  localparam logic [2:0] REG_ZEROES_TH = 3'd2;
  localparam logic [2:0] REG_XOVER_CPS = 3'd3;
  localparam logic [2:0] REG_MIN_FREQ  = 3'd4;
  localparam logic [2:0] REG_MAX_FREQ  = 3'd5;
  localparam logic [2:0] REG_XOVER_HZ  = 3'd6;

  localparam logic [FREQ_W-1:0] WARBLE_HZ [8] =
    '{13'd400, 13'd800, 13'd1200, 13'd1600, 13'd2000, 13'd1600, 13'd1200, 13'd800};
  localparam logic [FREQ_W-1:0] DESCEND_HZ [8] =
    '{13'd4000, 13'd3500, 13'd3000, 13'd2500, 13'd2000, 13'd1500, 13'd1000, 13'd500};
  localparam logic [5:0] CLIMB_PERIOD [10] =
    '{6'd16, 6'd14, 6'd12, 6'd10, 6'd9, 6'd8, 6'd7, 6'd6, 6'd5, 6'd4};
  localparam logic [4:0] BEEP_ON [10] =
    '{5'd10, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd2};

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_PEND} tone_state_t;
  typedef enum logic [2:0] {L_IDLE, L_MUL, L_DIV, L_SUM, L_DONE} lerp_state_t;

  typedef struct packed {
    logic              go;
    logic [BASE_W-1:0] base;
    logic [NUM_W-1:0]  num;
    logic [SPAN_W-1:0] span;
    logic [DEN_W-1:0]  den;
  } lerp_req_t;

  typedef struct packed {
    logic              done;
    logic [LERP_W-1:0] value;
  } lerp_rsp_t;

  // Climb rate 0..999 in hundreds (index 0..9), by comparison against steps of 100.
  function automatic logic [3:0] beep_index(input logic [9:0] cps);
    logic [3:0] idx;
    idx = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (cps >= 10'(k * 100)) idx = idx + 4'd1;
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ hdl/vtbg_lerp.sv @@
// Serial interpolation unit: base + (num * span) / den, truncating toward zero.
// Bit-serial shift-add multiply, then restoring divide one bit per cycle.
// Depends on vtbg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vtbg_lerp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire vtbg_pkg::lerp_req_t req,
  output vtbg_pkg::lerp_rsp_t      rsp
);
  import vtbg_pkg::*;

  lerp_state_t lstate, lstate_next;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  mplier;
  logic [PROD_W-1:0] mcand;
  logic [PROD_W-1:0] acc;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dmag;
  logic              neg;
  logic [BASE_W-1:0] base;
  logic signed [LERP_W-1:0] value;

  logic [NUM_W-1:0]  num_mag;
  logic [SPAN_W-1:0] span_mag;
  logic [DEN_W-1:0]  den_mag;
  logic [DEN_W:0]    rem_sh;
  logic              quo_bit;
  logic signed [LERP_W-1:0] quo_s;

  assign num_mag  = req.num[NUM_W-1]   ? (~req.num + 1'b1)  : req.num;
  assign span_mag = req.span[SPAN_W-1] ? (~req.span + 1'b1) : req.span;
  assign den_mag  = req.den[DEN_W-1]   ? (~req.den + 1'b1)  : req.den;

  assign rem_sh  = {rem, acc[PROD_W-1]};
  assign quo_bit = (rem_sh >= {1'b0, dmag});
  assign quo_s   = $signed({{(LERP_W-PROD_W){1'b0}}, acc});

  always_comb begin
    lstate_next = lstate;
    unique case (lstate)
      L_IDLE: if (req.go) lstate_next = L_MUL;
      L_MUL:  if (cnt == '0) lstate_next = L_DIV;
      L_DIV:  if (cnt == '0) lstate_next = L_SUM;
      L_SUM:  lstate_next = L_DONE;
      L_DONE: lstate_next = L_IDLE;
      default: lstate_next = L_IDLE;
    endcase
  end

  always_comb begin
    rsp.done  = (lstate == L_DONE);
    rsp.value = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lstate <= L_IDLE;
    end else begin
      lstate <= lstate_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (lstate)
      L_IDLE: begin
        mplier <= num_mag;
        mcand  <= {{(PROD_W-SPAN_W){1'b0}}, span_mag};
        acc    <= '0;
        dmag   <= den_mag;
        neg    <= req.num[NUM_W-1] ^ req.span[SPAN_W-1] ^ req.den[DEN_W-1];
        base   <= req.base;
        cnt    <= CNT_W'(MUL_STEPS - 1);
      end
      L_MUL: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[NUM_W-1:1]};
        if (cnt == '0) begin
          cnt <= CNT_W'(DIV_STEPS - 1);
          rem <= '0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      L_DIV: begin
        rem <= quo_bit ? DEN_W'(rem_sh - {1'b0, dmag}) : rem_sh[DEN_W-1:0];
        acc <= {acc[PROD_W-2:0], quo_bit};
        cnt <= cnt - 1'b1;
      end
      L_SUM: begin
        value <= $signed({{(LERP_W-BASE_W){base[BASE_W-1]}}, base}) + (neg ? -quo_s : quo_s);
      end
      L_DONE: begin
      end
      default: begin
      end
    endcase
  end

  `VTBG_ASSERT(a_go_when_idle, clk, rst, req.go |-> lstate == L_IDLE, "lerp request while busy")
  `VTBG_ASSERT(a_go_den_nonzero, clk, rst, req.go |-> req.den != '0, "lerp request with zero divisor")
  `VTBG_ASSERT(a_rem_below_den, clk, rst, (lstate == L_DIV) |-> rem < dmag, "divide remainder out of range")

endmodule

`default_nettype wire

@@ hdl/vario_tone_beep_generator_unit.sv @@
// Vario tone generator top level: one climb-rate request in, one tone request out.
// Uses vtbg_pkg, vtbg_lerp and assert_macros.svh.
//
// Usage:
//   Rate channel (rate_valid/rate_stall, climb_rate_cps) carries one tick of climb
//   rate; tone channel (tone_valid/tone_stall, tone_freq_hz, tone_update) returns
//   exactly one request per tick. A request is taken on a rising edge with valid
//   high and stall low.
//   Result path: a counting tick, or a new beep that needs no interpolation, goes
//   to the output register as it is taken, or to the pending register if the
//   output is held. A new beep in the sink, climb or zeroes band runs the serial
//   interpolation unit (multiply, divide, sum, handoff) before its result goes out.
//   Throughput: one tick per cycle while counting and the output is not held; when
//   a beep starts, no new tick is taken until the serial multiply-divide is done.
//   Stall: the output register holds while tone_stall is high; one further tick
//   is taken and its result waits in a pending register; then rate_stall rises.
//   Reset: rst is synchronous; it restores the register defaults and clears the
//   tone state. Writes on cfg_write (cfg_index, cfg_data) also clear the tone
//   state; an index beyond the register list is ignored.
`default_nettype none
`include "assert_macros.svh"

module vario_tone_beep_generator_unit (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        rate_valid,
  output logic              rate_stall,
  input  wire  logic [11:0] climb_rate_cps,
  output logic              tone_valid,
  input  wire  logic        tone_stall,
  output logic [12:0]       tone_freq_hz,
  output logic              tone_update,
  input  wire  logic        cfg_write,
  input  wire  logic [2:0]  cfg_index,
  input  wire  logic [12:0] cfg_data
);
  import vtbg_pkg::*;

  tone_state_t state, state_next;

  logic [10:0] sink_th;
  logic [9:0]  climb_th;
  logic [10:0] zeroes_th;
  logic [9:0]  xover_cps;
  logic [12:0] min_freq;
  logic [12:0] max_freq;
  logic [12:0] xover_freq;

  logic [11:0] latched_rate;
  logic [12:0] current_freq;
  logic [5:0]  period_left;
  logic [4:0]  on_ticks;
  logic [5:0]  tick_count;

  logic [12:0] pend_freq;
  logic        pend_upd;

  logic signed [RATE_W-1:0] cps13, lat13, sink13, zth13, climb13, xcps13;
  logic signed [SPAN_W-1:0] min15, max15, xf15;
  logic        accept, out_free, start_cond, cfg_hit;
  logic        lerp_band, st_lerp;
  logic [5:0]  st_period;
  logic [4:0]  st_on;
  logic [12:0] st_direct;
  logic [3:0]  beep_idx;
  logic signed [RATE_W-1:0] den13;
  logic [5:0]  tick_inc;
  logic [12:0] nf;
  logic        cd_upd;
  logic        res_now, res_upd_d;
  logic [12:0] res_freq_d, lerp_freq;
  lerp_req_t   lreq;
  lerp_rsp_t   lrsp;

  function automatic logic [12:0] clamp_freq(input logic signed [LERP_W-1:0] f,
                                             input logic [12:0] lo,
                                             input logic [12:0] hi);
    logic [12:0] r;
    if (f < $signed({{(LERP_W-13){1'b0}}, lo})) r = lo;
    else if (f > $signed({{(LERP_W-13){1'b0}}, hi})) r = hi;
    else r = f[12:0];
    return r;
  endfunction

  assign cps13   = $signed({climb_rate_cps[11], climb_rate_cps});
  assign lat13   = $signed({latched_rate[11], latched_rate});
  assign sink13  = $signed({{2{sink_th[10]}}, sink_th});
  assign zth13   = $signed({{2{zeroes_th[10]}}, zeroes_th});
  assign climb13 = $signed({3'b000, climb_th});
  assign xcps13  = $signed({3'b000, xover_cps});
  assign min15   = $signed({2'b00, min_freq});
  assign max15   = $signed({2'b00, max_freq});
  assign xf15    = $signed({2'b00, xover_freq});

  assign accept     = rate_valid && !rate_stall;
  assign out_free   = !tone_valid || !tone_stall;
  assign start_cond = (period_left == '0) || (cps13 >= climb13 && lat13 < climb13);
  assign cfg_hit    = cfg_write && (cfg_index <= REG_XOVER_HZ);
  assign lerp_freq  = clamp_freq($signed(lrsp.value), min_freq, max_freq);

  // Band decode for a new beep.
  always_comb begin
    st_period = '0;
    st_on     = '0;
    st_direct = '0;
    lerp_band = 1'b0;
    beep_idx  = beep_index(cps13[9:0]);
    lreq.base = {1'b0, min_freq};
    lreq.num  = NUM_W'(cps13 - zth13);
    lreq.span = SPAN_W'(xf15 - min15);
    den13     = xcps13 - zth13;
    if (cps13 <= sink13) begin
      if (cps13 <= -MAX_CPS) begin
        st_period = 6'(OFFSCALE_TICKS);
        st_on     = 5'(OFFSCALE_TICKS);
        st_direct = DESCEND_HZ[0];
      end else begin
        st_period = 6'(SINK_PERIOD);
        st_on     = 5'(SINK_ON);
        lerp_band = 1'b1;
        lreq.base = {2'b00, max_freq[12:1]};
        lreq.num  = NUM_W'(cps13 + MAX_CPS);
        lreq.span = SPAN_W'(min15 + SPAN_W'(SINK_SPAN_HZ) - $signed({3'b000, max_freq[12:1]}));
        den13     = sink13 + MAX_CPS;
      end
    end else if (cps13 >= climb13) begin
      if (cps13 >= MAX_CPS) begin
        st_period = 6'(OFFSCALE_TICKS);
        st_on     = 5'(OFFSCALE_TICKS);
        st_direct = WARBLE_HZ[0];
      end else begin
        st_period = CLIMB_PERIOD[beep_idx];
        st_on     = BEEP_ON[beep_idx];
        lerp_band = 1'b1;
        if (cps13 > xcps13) begin
          lreq.base = {1'b0, xover_freq};
          lreq.num  = NUM_W'(cps13 - xcps13);
          lreq.span = SPAN_W'(max15 - xf15);
          den13     = MAX_CPS - xcps13;
        end
      end
    end else if (cps13 >= zth13) begin
      st_period = 6'(ZEROES_PERIOD);
      st_on     = 5'(ZEROES_ON);
      lerp_band = 1'b1;
    end
    lreq.den = den13[DEN_W-1:0];
    st_lerp  = lerp_band && (den13 != '0);
    if (lerp_band && den13 == '0) begin
      st_direct = clamp_freq($signed({{(LERP_W-13){1'b0}}, min_freq}), min_freq, max_freq);
    end
    lreq.go  = accept && start_cond && st_lerp;
  end

  // Countdown within a running beep.
  always_comb begin
    tick_inc = tick_count + 6'd1;
    if (tick_inc >= {1'b0, on_ticks}) nf = '0;
    else if (lat13 >= MAX_CPS) nf = WARBLE_HZ[tick_inc[2:0]];
    else if (lat13 <= -MAX_CPS) nf = DESCEND_HZ[tick_inc[2:0]];
    else if (lat13 <= sink13) begin
      nf = (current_freq > 13'(SINK_STEP_HZ)) ? current_freq - 13'(SINK_STEP_HZ) : '0;
    end else nf = current_freq;
    cd_upd = (nf != current_freq);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && start_cond && st_lerp) state_next = S_CALC;
        else if (accept && !out_free) state_next = S_PEND;
      end
      S_CALC: if (lrsp.done) state_next = out_free ? S_IDLE : S_PEND;
      S_PEND: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rate_stall = (state != S_IDLE);
    res_now    = 1'b0;
    res_freq_d = pend_freq;
    res_upd_d  = pend_upd;
    unique case (state)
      S_IDLE: begin
        res_now    = accept && !(start_cond && st_lerp);
        res_freq_d = start_cond ? st_direct : nf;
        res_upd_d  = start_cond ? 1'b1 : cd_upd;
      end
      S_CALC: begin
        res_now    = lrsp.done;
        res_freq_d = lerp_freq;
        res_upd_d  = 1'b1;
      end
      S_PEND: res_now = 1'b1;
      default: res_now = 1'b0;
    endcase
  end

  vtbg_lerp u_lerp (
    .clk (clk),
    .rst (rst),
    .req (lreq),
    .rsp (lrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tone_valid   <= 1'b0;
      sink_th      <= 11'h706;
      climb_th     <= 10'd50;
      zeroes_th    <= 11'd5;
      xover_cps    <= 10'd400;
      min_freq     <= 13'd200;
      max_freq     <= 13'd3200;
      xover_freq   <= 13'd1000;
      latched_rate <= '0;
      current_freq <= '0;
      period_left  <= '0;
      on_ticks     <= '0;
      tick_count   <= '0;
    end else begin
      state <= state_next;
      if (res_now && out_free) tone_valid <= 1'b1;
      else if (out_free) tone_valid <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          REG_SINK_TH:   sink_th    <= cfg_data[10:0];
          REG_CLIMB_TH:  climb_th   <= cfg_data[9:0];
          REG_ZEROES_TH: zeroes_th  <= cfg_data[10:0];
          REG_XOVER_CPS: xover_cps  <= cfg_data[9:0];
          REG_MIN_FREQ:  min_freq   <= cfg_data;
          REG_MAX_FREQ:  max_freq   <= cfg_data;
          REG_XOVER_HZ:  xover_freq <= cfg_data;
          default: begin
          end
        endcase
      end

      if (cfg_hit) begin
        latched_rate <= '0;
        current_freq <= '0;
        period_left  <= '0;
        on_ticks     <= '0;
        tick_count   <= '0;
      end else if (accept) begin
        if (start_cond) begin
          latched_rate <= climb_rate_cps;
          tick_count   <= '0;
          period_left  <= st_period;
          on_ticks     <= st_on;
          current_freq <= st_direct;
        end else begin
          tick_count   <= tick_inc;
          period_left  <= period_left - 6'd1;
          current_freq <= nf;
        end
      end else if (state == S_CALC && lrsp.done) begin
        current_freq <= lerp_freq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_now && out_free) begin
      tone_freq_hz <= res_freq_d;
      tone_update  <= res_upd_d;
    end
    if (res_now && !out_free) begin
      pend_freq <= res_freq_d;
      pend_upd  <= res_upd_d;
    end
  end

  `VTBG_ASSERT(a_pend_has_output, clk, rst, (state == S_PEND) |-> tone_valid, "pending result without a held output")
  `VTBG_ASSERT(a_done_in_calc, clk, rst, lrsp.done |-> state == S_CALC, "interpolation result with no request waiting")
  `VTBG_ASSERT(a_calc_has_period, clk, rst, (state == S_CALC) |-> period_left != '0, "interpolated beep with empty period")

endmodule

`default_nettype wire
